### rtl/tpd_pkg.sv
`timescale 1ns / 1ps

package tpd_pkg;

   localparam int MAX_VERTICES = 1024;
   localparam int VTX_W        = 11;
   localparam int WGT_W        = 16;
   localparam int DIST_W       = 27;
   localparam int IDX_W        = $clog2(MAX_VERTICES);
   localparam int STEP_W       = $clog2(MAX_VERTICES + 1);

   localparam logic [DIST_W-1:0] DIST_MAX = '1;

   typedef logic [IDX_W-1:0] idx_type;

   typedef enum logic {
      CMD_LOAD  = 1'b0,
      CMD_QUERY = 1'b1
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COMPARE,
      ST_UP,
      ST_JOINT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [VTX_W-1:0] parent;
      logic [VTX_W-1:0] level;
      logic [WGT_W-1:0] weight;
   } entry_type;

   // controller to datapath
   typedef struct packed {
      logic start_query;
      logic write_entry;
      logic set_side;
      logic step_up;
      logic enter_joint;
      logic step_joint;
      logic load_out;
   } ctl_type;

   // datapath to controller
   typedef struct packed {
      logic trivial;
      logic lvl_a_gt_b;
      logic lvl_a_lt_b;
      logic up_done;
      logic up_parent_bad;
      logic joint_done;
      logic joint_parent_bad;
      logic out_free;
   } stat_type;

   function automatic logic vertex_ok(input logic [VTX_W-1:0] v);
      return (v != '0) && (32'(v) <= 32'(MAX_VERTICES));
   endfunction

   function automatic idx_type to_index(input logic [VTX_W-1:0] v);
      logic [31:0] d;
      d = 32'(v) - 32'd1;
      return d[IDX_W-1:0];
   endfunction

endpackage

### rtl/tpd_table.sv
`timescale 1ns / 1ps

module tpd_table (
   input  logic                clock,
   input  logic                wr_en,
   input  tpd_pkg::idx_type    wr_idx,
   input  tpd_pkg::entry_type  wr_data,
   input  tpd_pkg::idx_type    rd_idx_a,
   input  tpd_pkg::idx_type    rd_idx_b,
   output tpd_pkg::entry_type  rd_a,
   output tpd_pkg::entry_type  rd_b
);

   tpd_pkg::entry_type mem [tpd_pkg::MAX_VERTICES];
   tpd_pkg::entry_type rd_a_ff;
   tpd_pkg::entry_type rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
      rd_a_ff <= mem[rd_idx_a];
      rd_b_ff <= mem[rd_idx_b];
   end

   assign rd_a = rd_a_ff;
   assign rd_b = rd_b_ff;

endmodule

### rtl/tpd_datapath.sv
`timescale 1ns / 1ps

module tpd_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  tpd_pkg::ctl_type                ctl,
   output tpd_pkg::stat_type               stat,
   input  logic [tpd_pkg::VTX_W-1:0]       req_vertex_a,
   input  logic [tpd_pkg::VTX_W-1:0]       req_vertex_b,
   input  logic [tpd_pkg::VTX_W-1:0]       req_parent_vertex,
   input  logic [tpd_pkg::VTX_W-1:0]       req_depth_level,
   input  logic [tpd_pkg::WGT_W-1:0]       req_edge_weight,
   input  logic                            rsp_stall,
   output logic                            rsp_valid,
   output logic [tpd_pkg::DIST_W-1:0]      rsp_distance
);

   tpd_pkg::idx_type               ia_ff, ia_in;
   tpd_pkg::idx_type               ib_ff, ib_in;
   logic [tpd_pkg::DIST_W-1:0]     sum_ff, sum_in;
   logic [tpd_pkg::STEP_W-1:0]     steps_ff, steps_in;
   logic                           up_b_ff, up_b_in;
   logic                           out_valid_ff, out_valid_in;
   logic [tpd_pkg::DIST_W-1:0]     out_dist_ff, out_dist_in;

   tpd_pkg::entry_type             rd_a, rd_b, up_ent, wr_data;
   logic                           wr_en;
   logic                           steps_max;
   logic [tpd_pkg::WGT_W:0]        addend;
   logic [tpd_pkg::DIST_W:0]       sum_wide;
   logic [tpd_pkg::DIST_W-1:0]     sum_sat;

   assign wr_en          = ctl.write_entry && tpd_pkg::vertex_ok(req_vertex_a);
   assign wr_data.parent = req_parent_vertex;
   assign wr_data.level  = req_depth_level;
   assign wr_data.weight = req_edge_weight;

   tpd_table u_table (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_idx   (tpd_pkg::to_index(req_vertex_a)),
      .wr_data  (wr_data),
      .rd_idx_a (ia_in),
      .rd_idx_b (ib_in),
      .rd_a     (rd_a),
      .rd_b     (rd_b)
   );

   assign up_ent    = up_b_ff ? rd_b : rd_a;
   assign steps_max = (steps_ff == tpd_pkg::STEP_W'(tpd_pkg::MAX_VERTICES));

   // saturating accumulate of the climbing side's edge weight, or of both sides' weights in a joint climb
   always_comb begin
      if (ctl.step_joint) begin
         addend = {1'b0, rd_a.weight} + {1'b0, rd_b.weight};
      end else begin
         addend = {1'b0, up_ent.weight};
      end
      sum_wide = {1'b0, sum_ff} + (tpd_pkg::DIST_W + 1)'(addend);
      if (sum_wide > {1'b0, tpd_pkg::DIST_MAX}) begin
         sum_sat = tpd_pkg::DIST_MAX;
      end else begin
         sum_sat = sum_wide[tpd_pkg::DIST_W-1:0];
      end
   end

   always_comb begin
      stat.trivial          = (req_vertex_a == req_vertex_b)
                              || !tpd_pkg::vertex_ok(req_vertex_a)
                              || !tpd_pkg::vertex_ok(req_vertex_b);
      stat.lvl_a_gt_b       = rd_a.level > rd_b.level;
      stat.lvl_a_lt_b       = rd_a.level < rd_b.level;
      stat.up_done          = (rd_a.level == rd_b.level) || steps_max;
      stat.up_parent_bad    = !tpd_pkg::vertex_ok(up_ent.parent);
      stat.joint_done       = (ia_ff == ib_ff) || steps_max;
      stat.joint_parent_bad = !tpd_pkg::vertex_ok(rd_a.parent)
                              || !tpd_pkg::vertex_ok(rd_b.parent);
      stat.out_free         = !out_valid_ff || !rsp_stall;
   end

   always_comb begin
      ia_in        = ia_ff;
      ib_in        = ib_ff;
      sum_in       = sum_ff;
      steps_in     = steps_ff;
      up_b_in      = up_b_ff;
      out_valid_in = out_valid_ff;
      out_dist_in  = out_dist_ff;

      if (ctl.start_query) begin
         ia_in  = tpd_pkg::to_index(req_vertex_a);
         ib_in  = tpd_pkg::to_index(req_vertex_b);
         sum_in = '0;
      end
      if (ctl.set_side) begin
         up_b_in  = stat.lvl_a_lt_b;
         steps_in = '0;
      end
      if (ctl.enter_joint) begin
         steps_in = '0;
      end
      if (ctl.step_up) begin
         sum_in   = sum_sat;
         steps_in = steps_ff + 1'b1;
         if (up_b_ff) begin
            ib_in = tpd_pkg::to_index(rd_b.parent);
         end else begin
            ia_in = tpd_pkg::to_index(rd_a.parent);
         end
      end
      if (ctl.step_joint) begin
         sum_in   = sum_sat;
         steps_in = steps_ff + 1'b1;
         ia_in    = tpd_pkg::to_index(rd_a.parent);
         ib_in    = tpd_pkg::to_index(rd_b.parent);
      end

      if (ctl.load_out) begin
         out_valid_in = 1'b1;
         out_dist_in  = sum_ff;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      ia_ff       <= ia_in;
      ib_ff       <= ib_in;
      sum_ff      <= sum_in;
      steps_ff    <= steps_in;
      up_b_ff     <= up_b_in;
      out_dist_ff <= out_dist_in;
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_distance = out_dist_ff;

endmodule

### rtl/tpd_control.sv
`timescale 1ns / 1ps

module tpd_control (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_command,
   output logic               req_stall,
   input  tpd_pkg::stat_type  stat,
   output tpd_pkg::ctl_type   ctl
);

   tpd_pkg::state_type state_ff, state_in;
   logic               accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tpd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != tpd_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      case (state_ff)
         tpd_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_command == tpd_pkg::CMD_QUERY) begin
                  ctl.start_query = 1'b1;
                  state_in = stat.trivial ? tpd_pkg::ST_DONE : tpd_pkg::ST_COMPARE;
               end else begin
                  ctl.write_entry = 1'b1;
               end
            end
         end
         tpd_pkg::ST_COMPARE: begin
            ctl.set_side = 1'b1;
            if (stat.lvl_a_gt_b || stat.lvl_a_lt_b) begin
               state_in = tpd_pkg::ST_UP;
            end else begin
               state_in = tpd_pkg::ST_JOINT;
            end
         end
         tpd_pkg::ST_UP: begin
            if (stat.up_done) begin
               ctl.enter_joint = 1'b1;
               state_in = tpd_pkg::ST_JOINT;
            end else begin
               ctl.step_up = 1'b1;
               if (stat.up_parent_bad) begin
                  state_in = tpd_pkg::ST_DONE;
               end
            end
         end
         tpd_pkg::ST_JOINT: begin
            if (stat.joint_done) begin
               state_in = tpd_pkg::ST_DONE;
            end else begin
               ctl.step_joint = 1'b1;
               if (stat.joint_parent_bad) begin
                  state_in = tpd_pkg::ST_DONE;
               end
            end
         end
         tpd_pkg::ST_DONE: begin
            if (stat.out_free) begin
               ctl.load_out = 1'b1;
               state_in = tpd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tpd_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

### rtl/tree_path_distance_query.sv
// Weighted path length between two vertices of a rooted tree. A load beat
// (command 0) writes the parent, depth level and parent-edge weight of one
// vertex into an on-chip table; loads of a vertex outside 1..1024 are
// dropped. A query beat (command 1) returns one distance beat: the deeper
// endpoint climbs to the level of the other, then both climb together until
// they meet, and the edge weights passed are summed, saturating at 2^27-1.
// Equal or out-of-range endpoints hold the input and show 0 at the edge that
// ends the hold. Otherwise a query holds the input through level compare,
// single climbs plus an end check, joint climbs plus an end check, and the
// result hand-off. The single climbs are skipped when both endpoints start on
// one level, and climbing ends at a parent outside the table. There are at
// most 1024 single and 1024 joint climbs, and the hand-off also waits while
// the previous result has not left. The distance beat shows at the edge that
// ends the hold. One parent step is taken per cycle, bound by the registered
// read of the dual-read-port vertex table.
// The table has no reset; a query must only touch vertices that were loaded.
// The result sits in an output register, so the next beat is taken while a
// result still waits.
`timescale 1ns / 1ps

module tree_path_distance_query (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_command,
   input  logic [tpd_pkg::VTX_W-1:0]       req_vertex_a,
   input  logic [tpd_pkg::VTX_W-1:0]       req_vertex_b,
   input  logic [tpd_pkg::VTX_W-1:0]       req_parent_vertex,
   input  logic [tpd_pkg::VTX_W-1:0]       req_depth_level,
   input  logic [tpd_pkg::WGT_W-1:0]       req_edge_weight,
   // response channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [tpd_pkg::DIST_W-1:0]      rsp_distance
);

   // command and status between sequencer and datapath
   tpd_pkg::ctl_type  ctl;
   tpd_pkg::stat_type stat;

   // sequencer: idle, level compare, single climb, joint climb, result hand-off
   tpd_control u_control (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_stall   (req_stall),
      .stat        (stat),
      .ctl         (ctl)
   );

   // vertex table, endpoint indexes, step count, running sum, output register
   tpd_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .ctl               (ctl),
      .stat              (stat),
      .req_vertex_a      (req_vertex_a),
      .req_vertex_b      (req_vertex_b),
      .req_parent_vertex (req_parent_vertex),
      .req_depth_level   (req_depth_level),
      .req_edge_weight   (req_edge_weight),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_distance      (rsp_distance)
   );

endmodule

### rtl/tpd_checker.sv
`timescale 1ns / 1ps

module tpd_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input logic                            req_command,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic [tpd_pkg::DIST_W-1:0]      rsp_distance
);

   // a query beat makes the block busy in the next cycle
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_command == tpd_pkg::CMD_QUERY) |=> req_stall)
      else $error("query beat did not occupy the block");

   // a load beat leaves the block ready for the next beat
   a_load_ready: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_command == tpd_pkg::CMD_LOAD) |=> !req_stall)
      else $error("load beat stalled the request channel");

   // after reset the block is ready and shows no response
   a_reset_clean: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block not clean after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response beat dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_distance))
      else $error("response payload changed while stalled");

endmodule

bind tree_path_distance_query tpd_checker u_tpd_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .req_command  (req_command),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_distance (rsp_distance)
);
